FILE: rtl/core/gsws_pkg.sv
// Shared types, op codes, register indexes and time constants for the
// GPS search wake scheduler. No dependencies.

package gsws_pkg;

    // Event codes carried by the op field; unused codes behave as a query.
    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_LOCK  = 3'd1,
        OP_FAIL  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_QUERY = 3'd4
    } op_t;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_UPDATE_INTERVAL = 2'd0,
        REG_FAILURE_BACKOFF = 2'd1,
        REG_MAX_SEARCH      = 2'd2,
        REG_SMOOTH_WEIGHT   = 2'd3
    } reg_idx_t;

    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned WEIGHT_W = 17;

    localparam logic [31:0] ONE_MINUTE_MS = 32'd60000;
    localparam logic [31:0] FAIL_CAP_MS   = 32'd3600000;
    localparam logic [31:0] BASE_CLAMP_MS = 32'd900000;   // 15 minutes
    localparam logic [31:0] ABS_CLAMP_MS  = 32'd2700000;  // 45 minutes
    localparam logic [31:0] POST_FAIL_MS  = 32'd300000;   // 5 minutes
    localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [31:0]         UPDATE_INTERVAL_RST = 32'd120000;
    localparam logic [31:0]         FAILURE_BACKOFF_RST = 32'd900000;
    localparam logic [31:0]         MAX_SEARCH_RST      = 32'd900000;
    localparam logic [WEIGHT_W-1:0] SMOOTH_WEIGHT_RST   = 17'd13107;

    localparam logic [1:0] LOCKS_SAT = 2'd2;
    localparam logic [7:0] FAIL_SAT  = 8'd255;
    localparam logic [7:0] FAIL_RECENT_MAX = 8'd3;

    typedef struct packed {
        logic        search_active;
        logic [31:0] start_stamp;
        logic [31:0] end_stamp;
        logic [1:0]  locks_seen;
        logic [31:0] lock_estimate;
        logic [7:0]  fail_streak;
    } state_t;

    typedef struct packed {
        logic [31:0]         update_interval_ms;
        logic [31:0]         failure_backoff_ms;
        logic [31:0]         max_search_ms;
        logic [WEIGHT_W-1:0] smoothing_weight;
    } cfg_t;

    typedef struct packed {
        logic [30:0] wait_ms;
        logic        update_due;
        logic [31:0] elapsed_ms;
        logic        too_long;
        logic [31:0] predicted_lock_ms;
    } result_t;

endpackage

FILE: rtl/core/gsws_event.sv
// Next-state logic: applies one event to the scheduler state, including
// the Q1.16 lock-time smoothing. Depends on gsws_pkg.

module gsws_event (
    input  gsws_pkg::state_t           cur,
    input  logic [2:0]                 op,
    input  logic [31:0]                now_ms,
    input  logic [gsws_pkg::WEIGHT_W-1:0] weight,
    output gsws_pkg::state_t           nxt
);

    logic [31:0]                   lock_raw;
    logic [31:0]                   lock_ms;
    logic [gsws_pkg::WEIGHT_W-1:0] w_sat;
    logic [gsws_pkg::WEIGHT_W-1:0] w_inv;
    logic [48:0]                   prod_new;
    logic [48:0]                   prod_old;
    logic [49:0]                   acc;
    logic [31:0]                   est_next;

    // Lock time measured against this event's stamp; a negative span counts as 0.
    assign lock_raw = now_ms - cur.start_stamp;
    assign lock_ms  = lock_raw[31] ? 32'd0 : lock_raw;

    assign w_sat = (weight > gsws_pkg::ONE_Q16) ? gsws_pkg::ONE_Q16 : weight;
    assign w_inv = gsws_pkg::ONE_Q16 - w_sat;

    assign prod_new = 49'(lock_ms) * 49'(w_sat);
    assign prod_old = 49'(cur.lock_estimate) * 49'(w_inv);
    assign acc      = 50'(prod_new) + 50'(prod_old);

    always_comb
    begin
        case (cur.locks_seen)
            2'd0:    est_next = cur.lock_estimate;   // first lock is discarded
            2'd1:    est_next = lock_ms;
            default: est_next = acc[47:16];
        endcase
    end

    always_comb
    begin
        nxt = cur;
        case (op)
            gsws_pkg::OP_START:
            begin
                nxt.search_active = 1'b1;
                nxt.start_stamp   = now_ms;
            end
            gsws_pkg::OP_LOCK:
            begin
                nxt.search_active = 1'b0;
                nxt.end_stamp     = now_ms;
                nxt.lock_estimate = est_next;
                if (cur.locks_seen < gsws_pkg::LOCKS_SAT)
                begin
                    nxt.locks_seen = cur.locks_seen + 2'd1;
                end
                nxt.fail_streak   = 8'd0;
            end
            gsws_pkg::OP_FAIL:
            begin
                nxt.search_active = 1'b0;
                nxt.end_stamp     = now_ms;
                if (cur.fail_streak != gsws_pkg::FAIL_SAT)
                begin
                    nxt.fail_streak = cur.fail_streak + 8'd1;
                end
            end
            gsws_pkg::OP_CLEAR:
            begin
                nxt = '0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

FILE: rtl/core/gsws_verdict.sv
// Result logic: wait time, due flag, elapsed time and too-long verdict
// from the post-event state. Depends on gsws_pkg.

module gsws_verdict (
    input  gsws_pkg::state_t  st,
    input  gsws_pkg::cfg_t    cfg,
    input  logic [31:0]       now_ms,
    output gsws_pkg::result_t res
);

    logic [31:0] backoff;
    logic [31:0] interval;
    logic [31:0] delta;
    logic [31:0] wait_full;
    logic [31:0] elapsed;
    logic        est_nonzero;
    logic [31:0] clamp;
    logic        over_clamp;
    logic        over_post_fail;
    logic        over_limit;

    assign backoff = (cfg.failure_backoff_ms > gsws_pkg::FAIL_CAP_MS) ?
                     gsws_pkg::FAIL_CAP_MS : cfg.failure_backoff_ms;

    always_comb
    begin
        interval = cfg.update_interval_ms;
        if ((st.fail_streak != 8'd0) && (interval < backoff))
        begin
            interval = backoff;
        end
    end

    // Wrap-safe: a delta with the top bit set means the next search is overdue.
    assign delta     = st.end_stamp + interval - st.lock_estimate - now_ms;
    assign wait_full = delta[31] ? 32'd0 : delta;
    assign elapsed   = st.search_active ? (now_ms - st.start_stamp) : 32'd0;

    assign est_nonzero = (st.lock_estimate != 32'd0);

    // Estimate below the absolute clamp doubles without overflow and stays under 2x cap.
    always_comb
    begin
        clamp = gsws_pkg::BASE_CLAMP_MS;
        if (est_nonzero && (st.lock_estimate < gsws_pkg::ABS_CLAMP_MS) &&
            ({st.lock_estimate[30:0], 1'b0} > clamp))
        begin
            clamp = {st.lock_estimate[30:0], 1'b0};
        end
        if (clamp > gsws_pkg::ABS_CLAMP_MS)
        begin
            clamp = gsws_pkg::ABS_CLAMP_MS;
        end
    end

    assign over_clamp     = (elapsed > clamp);
    assign over_post_fail = (st.fail_streak != 8'd0) &&
                            (st.fail_streak <= gsws_pkg::FAIL_RECENT_MAX) &&
                            est_nonzero &&
                            (st.lock_estimate < gsws_pkg::POST_FAIL_MS) &&
                            (elapsed > gsws_pkg::POST_FAIL_MS);
    assign over_limit     = (elapsed > cfg.max_search_ms);

    assign res.wait_ms           = wait_full[30:0];
    assign res.update_due        = (wait_full == 32'd0);
    assign res.elapsed_ms        = elapsed;
    assign res.too_long          = over_clamp || over_post_fail || over_limit;
    assign res.predicted_lock_ms = st.lock_estimate;

endmodule

FILE: rtl/core/gps_search_wake_scheduler.sv
// Top level of the GPS search wake scheduler: handshakes, APB register
// file, state registers and the three-stage item pipeline.
// Depends on gsws_pkg, gsws_event and gsws_verdict.
//
// Usage
//   Input channel (in_valid/in_ready): one item = op + now_ms. The op is
//   applied to the search state, then one result is produced at the same
//   now_ms. Output channel (out_valid/out_ready): wait_ms, update_due,
//   elapsed_ms, too_long, predicted_lock_ms.
//   Pipeline: input register -> event stage (state update, lock-time
//   smoothing multiplies) -> result stage (wait and verdict compares) ->
//   output register. An accepted item's result is presented once it has
//   passed the result stage and been captured in the output register.
//   Throughput: one item per cycle while out_ready is high; the state
//   registers carry item N's update to item N+1's event stage, no bubble.
//   Stall: when out_ready is low the output holds; stages behind it keep
//   filling, so up to three items are in flight before in_ready drops.
//   Config: APB, registers at 0x0/0x4/0x8/0xC, pready always high, no wait
//   states. Write only while the pipeline is empty.
//   Reset (rst_n low, async): pipeline empties, search state clears to
//   zero, registers return to 120000 / 900000 / 900000 / 13107.

module gps_search_wake_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gsws_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    op,
    input  logic [31:0]                   now_ms,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [30:0]                   wait_ms,
    output logic                          update_due,
    output logic [31:0]                   elapsed_ms,
    output logic                          too_long,
    output logic [31:0]                   predicted_lock_ms
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    gsws_pkg::cfg_t   cfg_reg;
    gsws_pkg::cfg_t   cfg_next;
    logic             cfg_wr;
    gsws_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = gsws_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                gsws_pkg::REG_UPDATE_INTERVAL: cfg_next.update_interval_ms = pwdata;
                gsws_pkg::REG_FAILURE_BACKOFF: cfg_next.failure_backoff_ms = pwdata;
                gsws_pkg::REG_MAX_SEARCH:      cfg_next.max_search_ms      = pwdata;
                gsws_pkg::REG_SMOOTH_WEIGHT:
                    cfg_next.smoothing_weight = pwdata[gsws_pkg::WEIGHT_W-1:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            gsws_pkg::REG_UPDATE_INTERVAL: prdata = cfg_reg.update_interval_ms;
            gsws_pkg::REG_FAILURE_BACKOFF: prdata = cfg_reg.failure_backoff_ms;
            gsws_pkg::REG_MAX_SEARCH:      prdata = cfg_reg.max_search_ms;
            gsws_pkg::REG_SMOOTH_WEIGHT:
                prdata = {{(32 - gsws_pkg::WEIGHT_W){1'b0}}, cfg_reg.smoothing_weight};
            default:                       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.update_interval_ms <= gsws_pkg::UPDATE_INTERVAL_RST;
            cfg_reg.failure_backoff_ms <= gsws_pkg::FAILURE_BACKOFF_RST;
            cfg_reg.max_search_ms      <= gsws_pkg::MAX_SEARCH_RST;
            cfg_reg.smoothing_weight   <= gsws_pkg::SMOOTH_WEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage moves when the one ahead is empty
    // or moving.
    // ------------------------------------------------------------------
    logic        in_v_reg;
    logic [2:0]  in_op_reg;
    logic [31:0] in_now_reg;
    logic        mid_v_reg;
    logic [31:0] mid_now_reg;
    logic        out_v_reg;

    logic        out_adv;
    logic        mid_adv;
    logic        in_adv;
    logic        evt_fire;

    assign out_adv  = !out_v_reg || out_ready;
    assign mid_adv  = !mid_v_reg || out_adv;
    assign in_adv   = !in_v_reg || mid_adv;
    assign in_ready = in_adv;
    assign evt_fire = in_v_reg && mid_adv;

    // ------------------------------------------------------------------
    // Search state. It always equals the post-event state of the item in
    // the result stage, since the event stage only moves with it.
    // ------------------------------------------------------------------
    gsws_pkg::state_t state_reg;
    gsws_pkg::state_t state_next;
    gsws_pkg::state_t evt_state;

    gsws_event u_event (
        .cur    (state_reg),
        .op     (in_op_reg),
        .now_ms (in_now_reg),
        .weight (cfg_reg.smoothing_weight),
        .nxt    (evt_state)
    );

    assign state_next = evt_fire ? evt_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            mid_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
            state_reg <= '0;
        end
        else
        begin
            if (in_adv)
            begin
                in_v_reg <= in_valid;
            end
            if (mid_adv)
            begin
                mid_v_reg <= in_v_reg;
            end
            if (out_adv)
            begin
                out_v_reg <= mid_v_reg;
            end
            state_reg <= state_next;
        end
    end

    // Payload registers: no reset needed.
    gsws_pkg::result_t res;
    gsws_pkg::result_t out_reg;

    gsws_verdict u_verdict (
        .st     (state_reg),
        .cfg    (cfg_reg),
        .now_ms (mid_now_reg),
        .res    (res)
    );

    always_ff @(posedge clk)
    begin
        if (in_adv && in_valid)
        begin
            in_op_reg  <= op;
            in_now_reg <= now_ms;
        end
        if (evt_fire)
        begin
            mid_now_reg <= in_now_reg;
        end
        if (out_adv && mid_v_reg)
        begin
            out_reg <= res;
        end
    end

    assign out_valid         = out_v_reg;
    assign wait_ms           = out_reg.wait_ms;
    assign update_due        = out_reg.update_due;
    assign elapsed_ms        = out_reg.elapsed_ms;
    assign too_long          = out_reg.too_long;
    assign predicted_lock_ms = out_reg.predicted_lock_ms;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_locks_sat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.locks_seen != 2'd3)
        else $error("locks_seen went past saturation");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_fire && (in_op_reg == gsws_pkg::OP_CLEAR)) |=> (state_reg == '0))
        else $error("clear item did not zero the state");

    a_lock_resets_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_fire && (in_op_reg == gsws_pkg::OP_LOCK)) |=>
            ((state_reg.fail_streak == 8'd0) && !state_reg.search_active))
        else $error("lock item left fail streak or searching flag set");

    a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_v_reg && !out_adv) |=> (mid_v_reg && $stable(state_reg)))
        else $error("state changed while result stage was stalled");

endmodule

FILE: bench/gps_search_wake_scheduler_tb.sv
// Self-checking bench for gps_search_wake_scheduler: event items in, one schedule result out.
// Predicts each result in-bench, checks APB register readback and runs under mixed idling.
// Depends on gsws_pkg and the gps_search_wake_scheduler RTL.

module gps_search_wake_scheduler_tb;
    import gsws_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 5;
    // Watchdog bound on the run; it is well above the slowest correct run.
    localparam int CYCLE_LIMIT  = 400000;
    // Lets the pipeline settle, plus margin, before a register write or the end of the run.
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int FAIL_RUN = 260;

    // The op field has three spare codes above the last real event; they act as a query.
    localparam logic [2:0] OP_SPARE_FIRST = OP_QUERY + 3'd1;
    localparam int NUM_SPARE_OPS = 3;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic [2:0]          op;
    logic [31:0]         now_ms;
    logic                out_valid;
    logic                out_ready;
    logic [30:0]         wait_ms;
    logic                update_due;
    logic [31:0]         elapsed_ms;
    logic                too_long;
    logic [31:0]         predicted_lock_ms;

    gps_search_wake_scheduler i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .op                (op),
        .now_ms            (now_ms),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .wait_ms           (wait_ms),
        .update_due        (update_due),
        .elapsed_ms        (elapsed_ms),
        .too_long          (too_long),
        .predicted_lock_ms (predicted_lock_ms)
    );

    // Expected schedule results, oldest first, one per accepted item.
    result_t     schedule_queue[$];
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned cycle_count;

    // Idling knobs, in percent per cycle, plus a receiver hold-off counted in cycles.
    int unsigned gap_pct;
    int unsigned stall_pct;
    int unsigned hold_cycles;

    // Bench copy of the scheduler state and registers.
    state_t      sched;
    cfg_t        regs;

    // Running millisecond clock used to build realistic event sequences.
    logic [31:0] wall_ms;

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles, %0d results outstanding",
                         cycle_count, schedule_queue.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Predictor: applies one event to the bench state, then computes the
    // result at the same now_ms.
    // ------------------------------------------------------------------
    function automatic result_t schedule_step(input logic [2:0] code, input logic [31:0] stamp);
        result_t     r;
        logic [31:0] lock_ms;
        logic [16:0] w;
        logic [63:0] lock_wide;
        logic [63:0] est_wide;
        logic [63:0] w_new;
        logic [63:0] w_old;
        logic [63:0] blend;
        logic [31:0] interval;
        logic [31:0] backoff;
        logic [31:0] span;
        logic [31:0] elapsed;
        logic [31:0] clamp;
        logic [31:0] head;
        logic        verdict;

        case (code)
            OP_START:
            begin
                sched.search_active = 1'b1;
                sched.start_stamp   = stamp;
            end
            OP_LOCK:
            begin
                sched.search_active = 1'b0;
                sched.end_stamp     = stamp;
                lock_ms = sched.end_stamp - sched.start_stamp;
                // a lock that appears to end before it started counts as instant
                if (lock_ms[31])
                    lock_ms = '0;
                w = (regs.smoothing_weight > ONE_Q16) ? ONE_Q16 : regs.smoothing_weight;
                if (sched.locks_seen == 2'd1)
                    sched.lock_estimate = lock_ms;
                else if (sched.locks_seen >= LOCKS_SAT)
                begin
                    lock_wide = {32'b0, lock_ms};
                    est_wide  = {32'b0, sched.lock_estimate};
                    w_new     = {47'b0, w};
                    w_old     = {47'b0, ONE_Q16 - w};
                    blend     = lock_wide * w_new + est_wide * w_old;
                    sched.lock_estimate = blend[47:16];
                end
                if (sched.locks_seen < LOCKS_SAT)
                    sched.locks_seen = sched.locks_seen + 2'd1;
                sched.fail_streak = '0;
            end
            OP_FAIL:
            begin
                sched.search_active = 1'b0;
                sched.end_stamp     = stamp;
                if (sched.fail_streak < FAIL_SAT)
                    sched.fail_streak = sched.fail_streak + 8'd1;
            end
            OP_CLEAR:
                sched = '0;
            default:
                ;
        endcase

        interval = regs.update_interval_ms;
        if (sched.fail_streak != 0)
        begin
            backoff = (regs.failure_backoff_ms > FAIL_CAP_MS) ? FAIL_CAP_MS
                                                               : regs.failure_backoff_ms;
            if (interval < backoff)
                interval = backoff;
        end
        span = sched.end_stamp + interval - sched.lock_estimate - stamp;
        if (span[31])
            span = '0;

        elapsed = sched.search_active ? (stamp - sched.start_stamp) : '0;

        clamp = BASE_CLAMP_MS;
        if (sched.lock_estimate != 0 && sched.lock_estimate < ABS_CLAMP_MS)
        begin
            head = sched.lock_estimate << 1;
            if (head > clamp)
                clamp = head;
        end
        if (clamp > ABS_CLAMP_MS)
            clamp = ABS_CLAMP_MS;
        verdict = (elapsed > clamp);
        if (sched.fail_streak != 0 && sched.fail_streak <= FAIL_RECENT_MAX &&
            sched.lock_estimate != 0 && sched.lock_estimate < POST_FAIL_MS &&
            elapsed > POST_FAIL_MS)
            verdict = 1'b1;
        if (elapsed > regs.max_search_ms)
            verdict = 1'b1;

        r.wait_ms           = span[30:0];
        r.update_due        = (span == 0);
        r.elapsed_ms        = elapsed;
        r.too_long          = verdict;
        r.predicted_lock_ms = sched.lock_estimate;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_count, what, got, want);
        mismatches++;
    endtask

    // Output side: sample at the rising edge, compare against the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (schedule_queue.size() == 0)
                report_mismatch("result with nothing expected", {33'b0, wait_ms}, '0);
            else
            begin
                want = schedule_queue.pop_front();
                if (wait_ms !== want.wait_ms)
                    report_mismatch("wait_ms", wait_ms, want.wait_ms);
                if (update_due !== want.update_due)
                    report_mismatch("update_due", update_due, want.update_due);
                if (elapsed_ms !== want.elapsed_ms)
                    report_mismatch("elapsed_ms", elapsed_ms, want.elapsed_ms);
                if (too_long !== want.too_long)
                    report_mismatch("too_long", too_long, want.too_long);
                if (predicted_lock_ms !== want.predicted_lock_ms)
                    report_mismatch("predicted_lock_ms", predicted_lock_ms,
                                    want.predicted_lock_ms);
            end
        end
    end

    // Receiver: random stalls at the falling edge; a pending hold-off wins and
    // is counted down one cycle at a time.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sender side. All tasks start and end at a falling edge.
    // ------------------------------------------------------------------

    // Offers one item, holds it until accepted, predicts its result.
    // in_valid stays high on return so back-to-back items see no bubble.
    task automatic send_item(input logic [2:0] code, input logic [31:0] stamp);
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        in_valid <= 1'b1;
        op       <= code;
        now_ms   <= stamp;
        do
            @(posedge clk);
        while (!in_ready);
        schedule_queue.push_back(schedule_step(code, stamp));
        items_sent++;
        @(negedge clk);
    endtask

    // Sender pauses until every expected result is back, then lets the pipe settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (schedule_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Drops psel after the access and idles before returning, so the next transfer starts cleanly.
    task automatic check_reg(input reg_idx_t idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
            report_mismatch($sformatf("readback of %s", idx.name()), prdata, want);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Only called while the block is idle: APB setup + access, then readback.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        case (idx)
            REG_UPDATE_INTERVAL: regs.update_interval_ms = value;
            REG_FAILURE_BACKOFF: regs.failure_backoff_ms = value;
            REG_MAX_SEARCH:      regs.max_search_ms      = value;
            REG_SMOOTH_WEIGHT:   regs.smoothing_weight   = value[WEIGHT_W-1:0];
            default:             ;
        endcase
        // the readback's setup cycle also closes the write access
        check_reg(idx, (idx == REG_SMOOTH_WEIGHT) ? {15'b0, value[WEIGHT_W-1:0]} : value);
    endtask

    task automatic write_all_regs(input logic [31:0] interval, input logic [31:0] backoff,
                                  input logic [31:0] max_search, input logic [31:0] weight);
        write_reg(REG_UPDATE_INTERVAL, interval);
        write_reg(REG_FAILURE_BACKOFF, backoff);
        write_reg(REG_MAX_SEARCH, max_search);
        write_reg(REG_SMOOTH_WEIGHT, weight);
    endtask

    // Search durations that sit on the interesting edges of the verdict logic.
    function automatic logic [31:0] pick_duration();
        logic [31:0] delta;
        delta = $urandom_range(4) - 2;
        case ($urandom_range(9))
            0:       return $urandom_range(200000);
            1:       return POST_FAIL_MS + delta;
            2:       return BASE_CLAMP_MS + delta;
            3:       return ABS_CLAMP_MS + delta;
            4:       return (sched.lock_estimate << 1) + delta;
            5:       return regs.max_search_ms + delta;
            6:       return $urandom();
            7:       return $urandom_range(4000000);
            default: return $urandom_range(1500000);
        endcase
    endfunction

    // Mostly well-formed start / query / lock-or-fail searches with random
    // timing, mixed with noise items and the odd clear.
    task automatic run_searches(input int unsigned count);
        int unsigned stop_at;
        logic [31:0] dur;
        int unsigned pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            // the running clock drifts forward, sometimes jumping to anywhere
            wall_ms = ($urandom_range(19) == 0) ? $urandom() : wall_ms + $urandom_range(300000);
            if (pick < 75)
            begin
                dur = pick_duration();
                send_item(OP_START, wall_ms);
                repeat ($urandom_range(2))
                    send_item(OP_QUERY, wall_ms + $urandom_range(dur));
                send_item(($urandom_range(99) < 60) ? OP_LOCK : OP_FAIL, wall_ms + dur);
                wall_ms = wall_ms + dur;
                if ($urandom_range(1))
                    send_item(OP_QUERY, wall_ms + $urandom_range(4000000));
            end
            else if (pick < 77)
                send_item(OP_CLEAR, wall_ms);
            else if (pick < 90)
                send_item(3'($urandom_range(7)), wall_ms + $urandom_range(3000000));
            else
                send_item(3'($urandom_range(7)), $urandom());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_values();
        check_reg(REG_UPDATE_INTERVAL, UPDATE_INTERVAL_RST);
        check_reg(REG_FAILURE_BACKOFF, FAILURE_BACKOFF_RST);
        check_reg(REG_MAX_SEARCH, MAX_SEARCH_RST);
        check_reg(REG_SMOOTH_WEIGHT, {15'b0, SMOOTH_WEIGHT_RST});
    endtask

    // Every event, time extremes and each named corner, at default registers.
    task automatic test_directed_events();
        gap_pct   = 0;
        stall_pct = 0;
        send_item(OP_QUERY, 32'h0000_0000);
        send_item(OP_QUERY, 32'hFFFF_FFFF);
        send_item(OP_START, 32'd1000);
        send_item(OP_QUERY, 32'd1000 + BASE_CLAMP_MS);        // right on the clamp
        send_item(OP_QUERY, 32'd1001 + BASE_CLAMP_MS);        // one past it
        send_item(OP_LOCK, 32'd6000);                         // first lock, not learned
        send_item(OP_START, 32'd10000);
        send_item(OP_LOCK, 32'd70000);                        // second lock loads 60 s
        send_item(OP_START, 32'd100000);
        send_item(OP_FAIL, 32'd500000);
        send_item(OP_START, 32'd600000);
        send_item(OP_QUERY, 32'd600001 + POST_FAIL_MS);       // recent failure, short lock
        send_item(OP_LOCK, 32'd700000);                       // smoothed lock
        send_item(OP_LOCK, 32'd800000);                       // lock while idle, stale start
        send_item(OP_FAIL, 32'd900000);                       // failure while idle
        send_item(OP_START, 32'd1000000);
        send_item(OP_START, 32'd1200000);                     // restart while searching
        send_item(OP_LOCK, 32'd1100000);                      // ends before start: zero lock
        for (int i = 0; i < NUM_SPARE_OPS; i++)
            send_item(OP_SPARE_FIRST + i[2:0], 32'd1300000);  // spare codes act as query
        send_item(OP_START, 32'hFFFF_FF00);
        send_item(OP_QUERY, 32'h0000_0100);                   // elapsed across the wrap
        send_item(OP_CLEAR, 32'hDEAD_BEEF);
        send_item(OP_QUERY, 32'd5);
        wait_idle();
    endtask

    // Failure streak through the one-to-three window and on to saturation.
    task automatic test_fail_streak();
        send_item(OP_CLEAR, 32'd0);
        for (int i = 0; i < 2; i++)
        begin
            send_item(OP_START, 32'd100000 * (2 * i + 1));
            send_item(OP_LOCK, 32'd100000 * (2 * i + 2));
        end
        wall_ms = 32'd1000000;
        for (int i = 0; i < FAIL_RUN; i++)
        begin
            wall_ms = wall_ms + 32'd1000;
            send_item(OP_FAIL, wall_ms);
            if (i < 6 || i % 32 == 0 || i >= FAIL_RUN - 3)
            begin
                send_item(OP_START, wall_ms);
                send_item(OP_QUERY, wall_ms + POST_FAIL_MS + 32'd1);
            end
        end
        wait_idle();
    endtask

    // Register extremes, including weights of zero, exactly one and above one.
    task automatic test_register_extremes();
        write_all_regs('0, '0, '0, '0);
        run_searches(40);
        wait_idle();
        write_all_regs('1, '1, '1, '1);
        run_searches(40);
        wait_idle();
        write_all_regs(FAIL_CAP_MS - 1, FAIL_CAP_MS + 1, ABS_CLAMP_MS, {15'b0, ONE_Q16});
        run_searches(40);
        wait_idle();
        write_all_regs(UPDATE_INTERVAL_RST, FAIL_CAP_MS, POST_FAIL_MS, 32'd1);
        run_searches(40);
        wait_idle();
    endtask

    // Long receiver hold-off while items keep coming: the pipe fills and in_ready drops.
    task automatic test_backpressure();
        gap_pct     = 0;
        stall_pct   = 0;
        hold_cycles = HOLD_OFF_CYCLES;
        run_searches(40);
        wait_idle();
    endtask

    // Four idling mixes, each with its own random register setting.
    task automatic test_random_phases();
        int unsigned gaps[4]   = '{0, 47, 0, 25};
        int unsigned stalls[4] = '{0, 0, 47, 25};
        for (int p = 0; p < 4; p++)
        begin
            write_all_regs($urandom_range(3) == 0 ? $urandom() : $urandom_range(600000),
                           $urandom_range(3) == 0 ? $urandom() : $urandom_range(4000000),
                           $urandom_range(3) == 0 ? $urandom() : $urandom_range(3000000),
                           $urandom_range(7) == 0 ? $urandom() : $urandom_range(65536));
            gap_pct   = gaps[p];
            stall_pct = stalls[p];
            // stretches with no idling inside every phase
            run_searches(140);
            gap_pct   = 0;
            stall_pct = 0;
            run_searches(20);
            gap_pct   = gaps[p];
            stall_pct = stalls[p];
            run_searches(120);
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        op          = OP_QUERY;
        now_ms      = '0;
        gap_pct     = 0;
        stall_pct   = 0;
        hold_cycles = 0;
        mismatches  = 0;
        items_sent  = 0;
        results_seen = 0;
        wall_ms     = '0;
        sched       = '0;
        regs.update_interval_ms = UPDATE_INTERVAL_RST;
        regs.failure_backoff_ms = FAILURE_BACKOFF_RST;
        regs.max_search_ms      = MAX_SEARCH_RST;
        regs.smoothing_weight   = SMOOTH_WEIGHT_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_values();
        test_directed_events();
        test_fail_streak();
        test_register_extremes();
        test_backpressure();
        test_random_phases();

        wait_idle();
        $display("Covered %0d items / %0d results: every event and spare code, register extremes,",
                 items_sent, results_seen);
        $display("failure-streak saturation, a long output hold-off and four idling mixes.");
        if (mismatches == 0 && schedule_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
